FILE: rtl/core/hse_pkg.sv
// shared types, constants and codes of the histogram statistics equalizer
`timescale 1ns / 1ps
`default_nettype none

package hse_pkg;

  localparam int unsigned MaxPixels = 4194304;
  localparam int Bins  = 256;
  localparam int AddrW = 8;
  localparam int PixW  = 8;
  localparam int CntW  = 23;
  localparam int SumW  = 31;
  localparam int SqW   = 39;
  localparam int ProdW = 62;
  localparam int NnW   = 45;
  localparam int VarW  = 31;
  localparam int WideW = 64;
  localparam int LowW  = 32;
  localparam int IterW = 5;

  localparam logic [IterW-1:0] ItersMap  = 5'd8;
  localparam logic [IterW-1:0] ItersMean = 5'd16;
  localparam logic [IterW-1:0] ItersVar  = 5'd31;
  localparam logic [IterW-1:0] ItersSqrt = 5'd16;
  localparam logic [IterW-1:0] ItersMulN = 5'd23;
  localparam logic [IterW-1:0] ItersMulS = 5'd31;

  typedef enum logic [1:0] {
    ActClear  = 2'd0,
    ActAdd    = 2'd1,
    ActFinish = 2'd2,
    ActMap    = 2'd3
  } action_e;

  localparam logic KindStats = 1'b0;
  localparam logic KindPixel = 1'b1;

  localparam logic [1:0] ClsLow  = 2'd0;
  localparam logic [1:0] ClsMid  = 2'd1;
  localparam logic [1:0] ClsHigh = 2'd2;

  localparam logic [1:0] RegDark      = 2'd0;
  localparam logic [1:0] RegLight     = 2'd1;
  localparam logic [1:0] RegLowContr  = 2'd2;
  localparam logic [1:0] RegHighContr = 2'd3;

  localparam logic [7:0] DarkReset      = 8'd85;
  localparam logic [7:0] LightReset     = 8'd170;
  localparam logic [7:0] LowContrReset  = 8'd30;
  localparam logic [7:0] HighContrReset = 8'd70;

  typedef enum logic [1:0] {
    OpDiv  = 2'd0,
    OpSqrt = 2'd1,
    OpMul  = 2'd2
  } arith_op_e;

  typedef struct packed {
    logic             start;
    arith_op_e        op;
    logic [IterW-1:0] iters;
    logic [WideW-1:0] a;
    logic [WideW-1:0] b;
    logic [LowW-1:0]  l;
  } arith_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WideW-1:0] acc;
    logic [LowW-1:0]  quo;
  } arith_rsp_t;

  typedef struct packed {
    logic [4:0]      pad;
    logic            empty_frame;
    logic            overflowed;
    logic [CntW-1:0] frame_pixels;
    logic [1:0]      contrast_class;
    logic [1:0]      brightness_class;
    logic [CntW-1:0] peak_count;
    logic [14:0]     deviation_fixed;
    logic [15:0]     mean_fixed;
    logic [PixW-1:0] mapped_pixel;
  } out_data_t;

endpackage

`default_nettype wire

FILE: rtl/core/hse_arith.sv
// shared add/subtract unit stepping division, square root and multiplication
`timescale 1ns / 1ps
`default_nettype none

module hse_arith (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hse_pkg::arith_req_t req_i,
  output hse_pkg::arith_rsp_t      rsp_o
);
  import hse_pkg::*;

  logic             busy_q, done_q;
  arith_op_e        op_q;
  logic [IterW-1:0] cnt_q;
  logic [WideW-1:0] acc_q, b_q;
  logic [LowW-1:0]  l_q, quo_q;

  logic [WideW-1:0] opa, opb;
  logic             sub;
  logic [WideW:0]   sum;
  logic             ge;

  always_comb begin
    unique case (op_q)
      OpDiv: begin
        opa = {acc_q[WideW-2:0], l_q[LowW-1]};
        opb = b_q;
        sub = 1'b1;
      end
      OpSqrt: begin
        opa = {acc_q[WideW-3:0], l_q[LowW-1:LowW-2]};
        opb = {{(WideW-LowW-2){1'b0}}, quo_q, 2'b01};
        sub = 1'b1;
      end
      OpMul: begin
        opa = acc_q;
        opb = l_q[0] ? b_q : '0;
        sub = 1'b0;
      end
      default: begin
        opa = acc_q;
        opb = '0;
        sub = 1'b0;
      end
    endcase
    sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {{WideW{1'b0}}, sub};
    ge  = sum[WideW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OpDiv;
      cnt_q  <= '0;
      acc_q  <= '0;
      b_q    <= '0;
      l_q    <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == IterW'(1));
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= req_i.iters;
        acc_q  <= req_i.a;
        b_q    <= req_i.b;
        l_q    <= req_i.l;
        quo_q  <= '0;
      end else if (busy_q) begin
        unique case (op_q)
          OpDiv: begin
            acc_q <= ge ? sum[WideW-1:0] : opa;
            quo_q <= {quo_q[LowW-2:0], ge};
            l_q   <= {l_q[LowW-2:0], 1'b0};
          end
          OpSqrt: begin
            acc_q <= ge ? sum[WideW-1:0] : opa;
            quo_q <= {quo_q[LowW-2:0], ge};
            l_q   <= {l_q[LowW-3:0], 2'b00};
          end
          OpMul: begin
            acc_q <= sum[WideW-1:0];
            b_q   <= {b_q[WideW-2:0], 1'b0};
            l_q   <= {1'b0, l_q[LowW-1:1]};
          end
          default: begin
            acc_q <= acc_q;
          end
        endcase
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == IterW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.acc  = acc_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/hse_ram.sv
// 256-entry ram with per-entry valid bits, unwritten entries read as zero
`timescale 1ns / 1ps
`default_nettype none

module hse_ram #(
  parameter int Width = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      clr_i,
  input  wire logic                      rd_en_i,
  input  wire logic [hse_pkg::AddrW-1:0] rd_addr_i,
  output logic [Width-1:0]               rd_data_o,
  input  wire logic                      wr_en_i,
  input  wire logic [hse_pkg::AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0]          wr_data_i
);
  import hse_pkg::*;

  logic [Width-1:0] mem_q [Bins];
  logic [Bins-1:0]  vld_q;
  logic [Width-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/histogram_stats_equalizer.sv
// top level: histogram, frame statistics and equalization map sequencer
//
// Input stream: tuser carries the action (clear, add, finish, map), tdata the
// pixel. Clear completes in the idle state; add reads the bin and then writes
// it back incremented in StAddWr; map reads the map entry and then waits in
// StMapOut to load the output. Finish on a non-empty frame walks all 256 bins,
// one shared division each, then runs three multiplications, two divisions and
// a square root on the same shared add/subtract unit; an empty frame goes
// straight to StEmptyOut to load its result. The block accepts no item while
// one is being worked on.
// Output stream: tuser is the result kind, tdata the packed result. A result
// sits in an output register until taken; while the receiver stalls, the
// next result waits in its final state and no further item is accepted.
// Configuration writes are taken in any cycle and change four threshold
// registers used by finish.
// Reset clears histogram, map (valid bits), counters and the output register
// at once and loads the threshold registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none

module histogram_stats_equalizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // pixel[7:0]
  input  wire logic [1:0]  s_axis_tuser_i,   // action[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // mapped_pixel[7:0], mean_fixed[23:8], deviation_fixed[38:24],
  // peak_count[61:39], brightness_class[63:62], contrast_class[65:64],
  // frame_pixels[88:66], overflowed[89], empty_frame[90], zero[95:91]
  output logic [95:0]      m_axis_tdata_o,
  output logic             m_axis_tuser_o,   // result_kind[0]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  import hse_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StAddWr, StMapOut, StFinRd, StFinBin, StFinDiv, StFinNq, StFinSs,
    StFinNn, StFinVar, StFinMean, StFinSqrt, StFinOut, StEmptyOut
  } state_e;

  state_e           state_q;
  logic             pend_q;
  logic [CntW-1:0]  total_q, cum_q, peak_q;
  logic [SumW-1:0]  sum_q;
  logic             ovf_q;
  logic [7:0]       dark_q, light_q, lowc_q, highc_q;
  logic [PixW-1:0]  pix_q, v_q;
  logic [15:0]      vsq_q;
  logic [SqW-1:0]   prod_q, sq_q;
  logic [ProdW-1:0] nq_q, d_q;
  logic [NnW-1:0]   nn_q;
  logic [VarW-1:0]  var_q;
  logic             var_nz_q, mean_nz_q;
  logic [15:0]      mean_q;
  logic [14:0]      dev_q;
  logic             out_valid_q, out_kind_q;
  out_data_t        out_data_q;

  arith_req_t       areq;
  arith_rsp_t       arsp;
  logic             in_acc, out_free, compute, out_load;
  action_e          act;
  logic             hist_rd_en, hist_wr_en, map_rd_en, map_wr_en, map_clr, hist_clr;
  logic [AddrW-1:0] hist_rd_addr, map_rd_addr;
  logic [CntW-1:0]  hist_rd;
  logic [PixW-1:0]  map_rd;
  logic [SumW-1:0]  n255;
  logic [15:0]      lc_sq, hc_sq;
  logic [31:0]      var_ext;
  logic [1:0]       bright, contrast;
  out_data_t        stats, map_res, empty_res;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign act             = action_e'(s_axis_tuser_i);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;
  assign out_load        = out_free && ((state_q == StMapOut) || (state_q == StFinOut) ||
                                        (state_q == StEmptyOut));

  assign compute = (state_q == StFinDiv) || (state_q == StFinNq) || (state_q == StFinSs) ||
                   (state_q == StFinNn) || (state_q == StFinVar) ||
                   (state_q == StFinMean) || (state_q == StFinSqrt);

  assign n255 = {cum_q, 8'b0} - {8'b0, cum_q};

  always_comb begin
    areq       = '0;
    areq.start = compute && !pend_q;
    unique case (state_q)
      StFinDiv: begin
        areq.op    = OpDiv;
        areq.iters = ItersMap;
        areq.a     = {{(WideW-SumW+8){1'b0}}, n255[SumW-1:8]};
        areq.b     = {{(WideW-CntW){1'b0}}, total_q};
        areq.l     = {n255[7:0], 24'b0};
      end
      StFinNq: begin
        areq.op    = OpMul;
        areq.iters = ItersMulN;
        areq.b     = {{(WideW-SqW){1'b0}}, sq_q};
        areq.l     = {{(LowW-CntW){1'b0}}, total_q};
      end
      StFinSs: begin
        areq.op    = OpMul;
        areq.iters = ItersMulS;
        areq.b     = {{(WideW-SumW){1'b0}}, sum_q};
        areq.l     = {{(LowW-SumW){1'b0}}, sum_q};
      end
      StFinNn: begin
        areq.op    = OpMul;
        areq.iters = ItersMulN;
        areq.b     = {{(WideW-CntW){1'b0}}, total_q};
        areq.l     = {{(LowW-CntW){1'b0}}, total_q};
      end
      StFinVar: begin
        areq.op    = OpDiv;
        areq.iters = ItersVar;
        areq.a     = {{(WideW-ProdW+15){1'b0}}, d_q[ProdW-1:15]};
        areq.b     = {{(WideW-NnW){1'b0}}, nn_q};
        areq.l     = {d_q[14:0], 17'b0};
      end
      StFinMean: begin
        areq.op    = OpDiv;
        areq.iters = ItersMean;
        areq.a     = {{(WideW-SumW+8){1'b0}}, sum_q[SumW-1:8]};
        areq.b     = {{(WideW-CntW){1'b0}}, total_q};
        areq.l     = {sum_q[7:0], 24'b0};
      end
      StFinSqrt: begin
        areq.op    = OpSqrt;
        areq.iters = ItersSqrt;
        areq.l     = {{(LowW-VarW){1'b0}}, var_q};
      end
      default: begin
        areq.op = OpDiv;
      end
    endcase
  end

  hse_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (areq),
    .rsp_o  (arsp)
  );

  assign hist_clr     = in_acc && (act == ActClear);
  assign hist_rd_en   = (in_acc && (act == ActAdd)) || (state_q == StFinRd);
  assign hist_rd_addr = (state_q == StFinRd) ? v_q : s_axis_tdata_i;
  assign hist_wr_en   = (state_q == StAddWr);
  assign map_rd_en    = in_acc && (act == ActMap);
  assign map_rd_addr  = s_axis_tdata_i;
  assign map_wr_en    = (state_q == StFinDiv) && arsp.done;
  assign map_clr      = in_acc && (act == ActFinish) && (total_q == '0);

  hse_ram #(.Width(CntW)) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (hist_clr),
    .rd_en_i   (hist_rd_en),
    .rd_addr_i (hist_rd_addr),
    .rd_data_o (hist_rd),
    .wr_en_i   (hist_wr_en),
    .wr_addr_i (pix_q),
    .wr_data_i (hist_rd + 1'b1)
  );

  hse_ram #(.Width(PixW)) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (map_clr),
    .rd_en_i   (map_rd_en),
    .rd_addr_i (map_rd_addr),
    .rd_data_o (map_rd),
    .wr_en_i   (map_wr_en),
    .wr_addr_i (v_q),
    .wr_data_i (arsp.quo[PixW-1:0])
  );

  // classes from the exact quotients and nonzero remainders
  assign lc_sq   = {8'b0, lowc_q} * {8'b0, lowc_q};
  assign hc_sq   = {8'b0, highc_q} * {8'b0, highc_q};
  assign var_ext = {1'b0, var_q};

  always_comb begin
    priority if (mean_q < {dark_q, 8'b0}) begin
      bright = ClsLow;
    end else if ((mean_q > {light_q, 8'b0}) || ((mean_q == {light_q, 8'b0}) && mean_nz_q)) begin
      bright = ClsHigh;
    end else begin
      bright = ClsMid;
    end
    priority if (var_ext < {lc_sq, 16'b0}) begin
      contrast = ClsLow;
    end else if ((var_ext > {hc_sq, 16'b0}) || ((var_ext == {hc_sq, 16'b0}) && var_nz_q)) begin
      contrast = ClsHigh;
    end else begin
      contrast = ClsMid;
    end
    stats                  = '0;
    stats.mean_fixed       = mean_q;
    stats.deviation_fixed  = dev_q;
    stats.peak_count       = peak_q;
    stats.brightness_class = bright;
    stats.contrast_class   = contrast;
    stats.frame_pixels     = total_q;
    stats.overflowed       = ovf_q;
    map_res                = '0;
    map_res.mapped_pixel   = map_rd;
    empty_res              = '0;
    empty_res.overflowed   = ovf_q;
    empty_res.empty_frame  = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_q      <= 1'b0;
      total_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      dark_q      <= DarkReset;
      light_q     <= LightReset;
      lowc_q      <= LowContrReset;
      highc_q     <= HighContrReset;
      pix_q       <= '0;
      v_q         <= '0;
      vsq_q       <= '0;
      cum_q       <= '0;
      peak_q      <= '0;
      prod_q      <= '0;
      sq_q        <= '0;
      nq_q        <= '0;
      d_q         <= '0;
      nn_q        <= '0;
      var_q       <= '0;
      var_nz_q    <= 1'b0;
      mean_q      <= '0;
      mean_nz_q   <= 1'b0;
      dev_q       <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KindStats;
      out_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegDark:      dark_q  <= cfg_data_i;
          RegLight:     light_q <= cfg_data_i;
          RegLowContr:  lowc_q  <= cfg_data_i;
          RegHighContr: highc_q <= cfg_data_i;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      if (compute) begin
        if (!pend_q) begin
          pend_q <= 1'b1;
        end
        if (arsp.done) begin
          pend_q <= 1'b0;
        end
      end

      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            unique case (act)
              ActClear: begin
                total_q <= '0;
                sum_q   <= '0;
                ovf_q   <= 1'b0;
              end
              ActAdd: begin
                if (total_q < CntW'(MaxPixels)) begin
                  pix_q   <= s_axis_tdata_i;
                  state_q <= StAddWr;
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              ActFinish: begin
                v_q    <= '0;
                vsq_q  <= '0;
                cum_q  <= '0;
                peak_q <= '0;
                sq_q   <= '0;
                if (total_q == '0) begin
                  state_q <= StEmptyOut;
                end else begin
                  state_q <= StFinRd;
                end
              end
              ActMap: begin
                state_q <= StMapOut;
              end
            endcase
          end
        end
        StAddWr: begin
          total_q <= total_q + 1'b1;
          sum_q   <= sum_q + {{(SumW-PixW){1'b0}}, pix_q};
          state_q <= StIdle;
        end
        StMapOut: begin
          if (out_free) begin
            out_kind_q <= KindPixel;
            out_data_q <= map_res;
            state_q    <= StIdle;
          end
        end
        StFinRd: begin
          state_q <= StFinBin;
        end
        StFinBin: begin
          if (hist_rd > peak_q) begin
            peak_q <= hist_rd;
          end
          cum_q   <= cum_q + hist_rd;
          prod_q  <= {{(SqW-CntW){1'b0}}, hist_rd} * {{(SqW-16){1'b0}}, vsq_q};
          state_q <= StFinDiv;
        end
        StFinDiv: begin
          if (arsp.done) begin
            sq_q <= sq_q + prod_q;
            if (v_q == '1) begin
              state_q <= StFinNq;
            end else begin
              vsq_q   <= vsq_q + {7'b0, v_q, 1'b1};
              v_q     <= v_q + 1'b1;
              state_q <= StFinRd;
            end
          end
        end
        StFinNq: begin
          if (arsp.done) begin
            nq_q    <= arsp.acc[ProdW-1:0];
            state_q <= StFinSs;
          end
        end
        StFinSs: begin
          if (arsp.done) begin
            d_q     <= nq_q - arsp.acc[ProdW-1:0];
            state_q <= StFinNn;
          end
        end
        StFinNn: begin
          if (arsp.done) begin
            nn_q    <= arsp.acc[NnW-1:0];
            state_q <= StFinVar;
          end
        end
        StFinVar: begin
          if (arsp.done) begin
            var_q    <= arsp.quo[VarW-1:0];
            var_nz_q <= (arsp.acc != '0);
            state_q  <= StFinMean;
          end
        end
        StFinMean: begin
          if (arsp.done) begin
            mean_q    <= arsp.quo[15:0];
            mean_nz_q <= (arsp.acc != '0);
            state_q   <= StFinSqrt;
          end
        end
        StFinSqrt: begin
          if (arsp.done) begin
            dev_q   <= arsp.quo[14:0];
            state_q <= StFinOut;
          end
        end
        StFinOut: begin
          if (out_free) begin
            out_kind_q <= KindStats;
            out_data_q <= stats;
            state_q    <= StIdle;
          end
        end
        StEmptyOut: begin
          if (out_free) begin
            out_kind_q <= KindStats;
            out_data_q <= empty_res;
            state_q    <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = out_data_q;

  a_ready_unit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !arsp.busy)
    else $error("input ready while shared unit busy");

  a_done_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arsp.done |-> (pend_q && compute))
    else $error("shared unit result without pending request");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(MaxPixels))
    else $error("pixel count beyond limit");

  a_pixel_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == KindPixel)) |-> (m_axis_tdata_o[95:8] == '0))
    else $error("pixel result carries statistics bits");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// self-checking bench for the histogram statistics equalizer stream block
`timescale 1ns / 1ps

module tb_top;
  import hse_pkg::*;

  typedef struct {
    action_e    act;
    logic [7:0] px;
  } request_t;

  typedef struct {
    logic      kind;
    out_data_t data;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [95:0] m_data;
  logic        m_user;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  request_t    pending_q[$];
  result_t     awaited_q[$];
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold = 1'b0;
  int          errors = 0;
  longint      cycles = 0;

  logic [22:0] bin_cnt[256];
  logic [7:0]  eq_map[256];
  logic [22:0] px_total;
  logic [30:0] px_sum;
  logic        ovf;
  logic [7:0]  limits[4];

  histogram_stats_equalizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      if (((r | (64'd1 << b)) * (r | (64'd1 << b))) <= x) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic void predict_request(action_e act, logic [7:0] px);
    result_t r;
    longint unsigned n, s, q, peak, cum, d, var16, dl, ll, lc, hc;
    r.kind = KindStats;
    r.data = '0;
    case (act)
      ActClear: begin
        foreach (bin_cnt[i]) bin_cnt[i] = '0;
        px_total = '0;
        px_sum = '0;
        ovf = 1'b0;
      end
      ActAdd: begin
        if (px_total < MaxPixels) begin
          bin_cnt[px]++;
          px_total++;
          px_sum += px;
        end else begin
          ovf = 1'b1;
        end
      end
      ActFinish: begin
        n = px_total;
        s = px_sum;
        r.data.overflowed = ovf;
        if (n == 0) begin
          foreach (eq_map[i]) eq_map[i] = '0;
          r.data.empty_frame = 1'b1;
        end else begin
          q = 0;
          peak = 0;
          cum = 0;
          for (int v = 0; v < 256; v++) begin
            if (bin_cnt[v] > peak) peak = bin_cnt[v];
            q += bin_cnt[v] * longint'(v * v);
            cum += bin_cnt[v];
            eq_map[v] = 8'((255 * cum) / n);
          end
          d = n * q - s * s;
          var16 = (((d / n) << 16) + (((d % n) << 16) / n)) / n;
          dl = limits[RegDark];
          ll = limits[RegLight];
          lc = limits[RegLowContr];
          hc = limits[RegHighContr];
          r.data.mean_fixed = 16'((s << 8) / n);
          r.data.deviation_fixed = 15'(int_sqrt(var16));
          r.data.peak_count = 23'(peak);
          r.data.frame_pixels = 23'(n);
          r.data.brightness_class = (s < dl * n) ? ClsLow : (s > ll * n) ? ClsHigh : ClsMid;
          r.data.contrast_class = (d < lc * lc * n * n) ? ClsLow :
                                  (d > hc * hc * n * n) ? ClsHigh : ClsMid;
        end
        awaited_q.push_back(r);
      end
      default: begin
        r.kind = KindPixel;
        r.data.mapped_pixel = eq_map[px];
        awaited_q.push_back(r);
      end
    endcase
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // request driver and random output ready
  always @(posedge clk_i) begin
    if (!s_valid || s_ready) begin
      if (rst_ni && !hold && pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_valid <= 1'b1;
        s_user  <= pending_q[0].act;
        s_data  <= pending_q[0].px;
        void'(pending_q.pop_front());
      end else begin
        s_valid <= 1'b0;
      end
    end
    m_ready <= ($urandom_range(99) >= recv_idle);
  end

  // acceptance tracking and result checking
  always @(posedge clk_i) begin
    out_data_t got;
    result_t   want;
    cycles++;
    if (cycles > 2000000) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_ni && s_valid && s_ready) predict_request(action_e'(s_user), s_data);
    if (rst_ni && m_valid && m_ready) begin
      got = out_data_t'(m_data);
      if (awaited_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, kind %0d data %h", $time, m_user, m_data);
      end else begin
        want = awaited_q.pop_front();
        check_field("result_kind", want.kind, m_user);
        check_field("mapped_pixel", want.data.mapped_pixel, got.mapped_pixel);
        check_field("mean_fixed", want.data.mean_fixed, got.mean_fixed);
        check_field("deviation_fixed", want.data.deviation_fixed, got.deviation_fixed);
        check_field("peak_count", want.data.peak_count, got.peak_count);
        check_field("brightness_class", want.data.brightness_class, got.brightness_class);
        check_field("contrast_class", want.data.contrast_class, got.contrast_class);
        check_field("frame_pixels", want.data.frame_pixels, got.frame_pixels);
        check_field("overflowed", want.data.overflowed, got.overflowed);
        check_field("empty_frame", want.data.empty_frame, got.empty_frame);
        check_field("pad", 0, got.pad);
      end
    end
  end

  function automatic void queue_request(action_e act, logic [7:0] px);
    request_t t;
    t.act = act;
    t.px = px;
    pending_q.push_back(t);
  endfunction

  function automatic int queue_frame();
    int sel, nadd, mode, center, cnt;
    cnt = 0;
    sel = $urandom_range(9);
    if (sel == 0) begin
      for (int i = 0; i < 5; i++) begin
        queue_request(action_e'(2'($urandom_range(3))), 8'($urandom_range(255)));
      end
      return 5;
    end
    if (sel != 1) begin
      queue_request(ActClear, 8'($urandom_range(255)));
      cnt++;
    end
    nadd = (sel == 2) ? 0 : (sel < 9) ? $urandom_range(1, 30) : $urandom_range(60, 120);
    mode = $urandom_range(3);
    center = $urandom_range(255);
    for (int i = 0; i < nadd; i++) begin
      case (mode)
        0: queue_request(ActAdd, 8'($urandom_range(255)));
        1: queue_request(ActAdd, 8'((center + $urandom_range(6)) > 255 ? 255 :
                                    center + $urandom_range(6)));
        2: queue_request(ActAdd, $urandom_range(1) ? 8'd255 : 8'd0);
        default: queue_request(ActAdd, 8'(center));
      endcase
    end
    queue_request(ActFinish, 8'($urandom_range(255)));
    for (int i = $urandom_range(3, 10); i > 0; i--) begin
      queue_request(ActMap, 8'($urandom_range(255)));
      cnt++;
    end
    return cnt + nadd + 1;
  endfunction

  task automatic wait_idle();
    wait (pending_q.size() == 0 && !s_valid && awaited_q.size() == 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    limits[idx] = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int snd, int rcv, int target);
    int sent;
    bit held;
    send_idle = snd;
    recv_idle = rcv;
    sent = 0;
    held = 1'b0;
    while (sent < target) begin
      sent += queue_frame();
      if (!held && sent > target / 2) begin
        held = 1'b1;
        hold = 1'b1;
        wait (!s_valid && awaited_q.size() == 0);
        hold = 1'b0;
      end
    end
    wait_idle();
  endtask

  initial begin
    foreach (bin_cnt[i]) bin_cnt[i] = '0;
    foreach (eq_map[i]) eq_map[i] = '0;
    px_total = '0;
    px_sum = '0;
    ovf = 1'b0;
    limits[RegDark] = DarkReset;
    limits[RegLight] = LightReset;
    limits[RegLowContr] = LowContrReset;
    limits[RegHighContr] = HighContrReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // map before any finish, empty frame, extreme pixels, kept histogram
    queue_request(ActMap, 8'd0);
    queue_request(ActMap, 8'd255);
    queue_request(ActFinish, 8'd0);
    queue_request(ActAdd, 8'd0);
    queue_request(ActAdd, 8'd255);
    queue_request(ActAdd, 8'd255);
    queue_request(ActFinish, 8'd255);
    queue_request(ActMap, 8'd0);
    queue_request(ActMap, 8'd128);
    queue_request(ActMap, 8'd255);
    queue_request(ActAdd, 8'd170);
    queue_request(ActAdd, 8'd85);
    queue_request(ActFinish, 8'd0);
    queue_request(ActMap, 8'd170);
    queue_request(ActClear, 8'd0);
    queue_request(ActAdd, 8'd100);
    queue_request(ActFinish, 8'd0);
    queue_request(ActMap, 8'd100);
    queue_request(ActMap, 8'd99);
    queue_request(ActClear, 8'd255);
    queue_request(ActFinish, 8'd0);
    queue_request(ActMap, 8'd100);
    wait_idle();

    for (int i = 0; i < 4; i++) write_reg(i[1:0], 8'd0);
    run_phase(25, 77, 250);
    for (int i = 0; i < 4; i++) write_reg(i[1:0], 8'd255);
    run_phase(77, 25, 250);
    for (int i = 0; i < 4; i++) write_reg(i[1:0], 8'($urandom_range(255)));
    run_phase(0, 0, 250);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/hse_pkg.sv
rtl/core/hse_arith.sv
rtl/core/hse_ram.sv
rtl/core/histogram_stats_equalizer.sv
bench/tb_top.sv
